// File: hdl/byte_transliterator_with_collapse_macros.svh
// Assertion macros shared by the byte transliterator checker.
`ifndef BYTE_TRANSLITERATOR_WITH_COLLAPSE_MACROS_SVH
`define BYTE_TRANSLITERATOR_WITH_COLLAPSE_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define BTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define BTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define BTC_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/btc_pkg.sv
// Shared types and constants of the byte transliterator.
`default_nettype none
package btc_pkg;

  // Item opcodes
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_TO    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_TO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COL     = 3'd4;

  localparam logic [15:0] END_COLUMN_RESET = 16'd9999;
  localparam logic [15:0] COLUMN_TOP       = 16'hFFFF;
  localparam logic [7:0]  CHAR_TAB         = 8'd9;
  localparam logic [7:0]  CHAR_NEWLINE     = 8'd10;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic              invert_set;
    logic signed [9:0] last_to_index;
    logic              collapse_enable;
    logic [15:0]       start_column;
    logic [15:0]       end_column;
  } btc_cfg_t;

  typedef struct packed {
    logic       emit;
    logic       use_to;
    logic       to_zero;
    logic [7:0] copy_byte;
  } btc_result_t;

endpackage
`default_nettype wire

// File: hdl/btc_match_mem.sv
// Match table: 256 entries of {present, position}, valid bits cleared at reset.
`default_nettype none
module btc_match_mem (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       we,
  input  wire logic [7:0] waddr,
  input  wire logic [9:0] wdata,
  input  wire logic       re,
  input  wire logic [7:0] raddr,
  output logic            rd_valid,
  output logic [9:0]      rd_data
);
  logic [9:0]   mem [256];
  logic [255:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_valid <= valid[raddr];
      rd_data  <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/btc_to_mem.sv
// TO table: replacement bytes, one write and one registered read port.
`default_nettype none
module btc_to_mem #(
  parameter int PATTERN_SIZE = 512,
  localparam int AW = (PATTERN_SIZE > 2) ? $clog2(PATTERN_SIZE) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rd_data
);
  logic [7:0] mem [PATTERN_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/btc_xlate.sv
// Per-byte decision: match index, column tracking, window and collapse-run state.
`default_nettype none
module btc_xlate #(
  parameter int PATTERN_SIZE = 512,
  parameter int TAB_STEP     = 8,
  localparam int AW = (PATTERN_SIZE > 2) ? $clog2(PATTERN_SIZE) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 consume,
  input  wire btc_pkg::btc_cfg_t    cfg,
  input  wire logic [1:0]           opcode,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 ent_valid,
  input  wire logic [9:0]           ent_data,
  output btc_pkg::btc_result_t      result,
  output logic [AW-1:0]             to_rd_addr
);
  import btc_pkg::*;

  localparam int PW = (TAB_STEP > 2) ? $clog2(TAB_STEP) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(TAB_STEP - 1);
  localparam logic [PW-1:0] PHASE_TOP  = PW'(65535 % TAB_STEP);

  // column and column mod TAB_STEP are tracked together
  logic [15:0]   column;
  logic [15:0]   column_next;
  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic          in_run;
  logic          in_run_next;

  logic              present;
  logic signed [10:0] last_ext;
  logic signed [10:0] idx;
  logic signed [10:0] to_idx;
  logic              last_ok;
  logic              hit;
  logic              is_tab;
  logic              is_nl;
  logic [16:0]       col_sum;
  logic              col_sat;
  logic [15:0]       col_adv;
  logic [PW-1:0]     phase_adv;
  logic [15:0]       col_cur;
  logic              outside;
  logic              nl_clear;

  always_comb begin
    present  = ent_valid & ent_data[9];
    last_ext = {cfg.last_to_index[9], cfg.last_to_index};
    last_ok  = ~cfg.last_to_index[9];
    if (!cfg.invert_set) begin
      idx = present ? signed'({2'b00, ent_data[8:0]}) : -11'sd1;
    end else begin
      idx = present ? -11'sd1 : last_ext + 11'sd1;
    end
    hit = last_ok && (idx >= last_ext);

    is_tab = (byte_value == CHAR_TAB);
    is_nl  = (byte_value == CHAR_NEWLINE);
    if (is_tab) begin
      col_sum = {1'b0, column} + 17'(TAB_STEP) - 17'(phase);
    end else begin
      col_sum = {1'b0, column} + 17'd1;
    end
    col_sat = col_sum[16];
    col_adv = col_sat ? COLUMN_TOP : col_sum[15:0];
    if (col_sat) begin
      phase_adv = PHASE_TOP;
    end else if (is_tab || phase == PHASE_LAST) begin
      phase_adv = '0;
    end else begin
      phase_adv = phase + PW'(1);
    end
    col_cur = col_adv - 16'd1;
    outside = (col_cur < cfg.start_column) ||
              ((cfg.end_column != 16'd0) && (col_cur > cfg.end_column));

    result.emit      = 1'b0;
    result.use_to    = 1'b0;
    result.copy_byte = byte_value;
    to_idx           = idx;
    in_run_next      = in_run;
    nl_clear         = 1'b0;

    if (in_run && hit) begin
      // swallowed inside a run
    end else if (!in_run && outside) begin
      result.emit = 1'b1;
      nl_clear    = is_nl;
    end else if (!in_run && cfg.collapse_enable && hit) begin
      result.emit   = 1'b1;
      result.use_to = 1'b1;
      to_idx        = last_ext;
      in_run_next   = 1'b1;
    end else begin
      in_run_next = 1'b0;
      nl_clear    = is_nl;
      if (!idx[10]) begin
        result.emit   = last_ok;
        result.use_to = 1'b1;
      end else begin
        result.emit = 1'b1;
      end
    end

    if (opcode != OP_DATA) begin
      result.emit = 1'b0;
    end

    result.to_zero = to_idx[10] ||
                     ({3'b000, to_idx[9:0]} >= 13'(PATTERN_SIZE));
    to_rd_addr     = AW'(to_idx[9:0]);

    column_next = nl_clear ? 16'd0 : col_adv;
    phase_next  = nl_clear ? '0 : phase_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      phase  <= '0;
      in_run <= 1'b0;
    end else if (consume && opcode == OP_DATA) begin
      column <= column_next;
      phase  <= phase_next;
      in_run <= in_run_next;
    end
  end
endmodule
`default_nettype wire

// File: hdl/byte_transliterator_with_collapse.sv
// Top level of the byte transliterator with collapse runs.
// Bytes stream in on s_axis and leave on m_axis after a translation set up by
// table-write items and five configuration registers. A result passes the
// input stage and the result register; one item is taken every cycle when
// the output side keeps up. The 256-entry match table is read at the data
// byte on the accepting edge; from the registered entry the per-byte decision
// is made, and as the item leaves the input stage the column and collapse-run
// state are updated while the TO table is read at the chosen position. The
// result register then holds the emitted byte until taken. Items that produce
// nothing (table writes, deleted or swallowed bytes, opcode three) leave the
// pipeline silently. The match table starts absent through per-entry valid
// bits, so no clearing pass is needed after reset. TO entries are undefined
// until written. Unenforced by the block, the user must write configuration
// through cfg_we/cfg_index/cfg_wdata while the block is idle.
`default_nettype none
module byte_transliterator_with_collapse #(
  parameter int PATTERN_SIZE = 512,
  parameter int TAB_STEP     = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: opcode[1:0], byte_value[9:2], table_address[18:10],
  //        entry_present[19], entry_position[28:20], zero pad [31:29]
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [btc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: out_byte[7:0]
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [btc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [btc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [btc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import btc_pkg::*;

  localparam int AW = (PATTERN_SIZE > 2) ? $clog2(PATTERN_SIZE) : 1;

  btc_cfg_t cfg;

  // input stage
  logic       v0;
  logic [1:0] op0;
  logic [7:0] byte0;
  logic [8:0] addr0;
  logic       accept;
  logic       consume;
  logic       load_out;

  // match table read
  logic       ent_valid;
  logic [9:0] ent_data;

  // decision and TO read
  btc_result_t    res;
  logic [AW-1:0]  to_rd_addr;
  logic [7:0]     to_rd_data;
  logic           to_we;

  // result stage
  logic        v1;
  btc_result_t res1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_set      <= 1'b0;
      cfg.last_to_index   <= -10'sd1;
      cfg.collapse_enable <= 1'b0;
      cfg.start_column    <= '0;
      cfg.end_column      <= END_COLUMN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INVERT_SET: cfg.invert_set      <= cfg_wdata[0];
        CFG_LAST_TO:    cfg.last_to_index   <= signed'(cfg_wdata[9:0]);
        CFG_COLLAPSE:   cfg.collapse_enable <= cfg_wdata[0];
        CFG_START_COL:  cfg.start_column    <= cfg_wdata;
        CFG_END_COL:    cfg.end_column      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or being drained; the
  // input stage moves into it at the same time, so a bubble is filled even
  // while a result waits.
  assign load_out      = ~v1 | m_axis_tready;
  assign consume       = v0 & load_out;
  assign s_axis_tready = ~v0 | load_out;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_axis_tready) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op0   <= s_axis_tdata[1:0];
      byte0 <= s_axis_tdata[9:2];
      addr0 <= s_axis_tdata[18:10];
    end
  end

  // Match entries are written on acceptance, in item order with the reads.
  btc_match_mem u_match (
    .clk      (clk),
    .rst      (rst),
    .we       (accept && s_axis_tdata[1:0] == OP_MATCH && !s_axis_tdata[18]),
    .waddr    (s_axis_tdata[17:10]),
    .wdata    ({s_axis_tdata[19], s_axis_tdata[28:20]}),
    .re       (s_axis_tready),
    .raddr    (s_axis_tdata[9:2]),
    .rd_valid (ent_valid),
    .rd_data  (ent_data)
  );

  btc_xlate #(
    .PATTERN_SIZE (PATTERN_SIZE),
    .TAB_STEP     (TAB_STEP)
  ) u_xlate (
    .clk        (clk),
    .rst        (rst),
    .consume    (consume),
    .cfg        (cfg),
    .opcode     (op0),
    .byte_value (byte0),
    .ent_valid  (ent_valid),
    .ent_data   (ent_data),
    .result     (res),
    .to_rd_addr (to_rd_addr)
  );

  // TO entries are written as the item leaves the input stage, the same
  // point at which later bytes issue their TO reads.
  assign to_we = consume && op0 == OP_TO && ({4'b0000, addr0} < 13'(PATTERN_SIZE));

  btc_to_mem #(
    .PATTERN_SIZE (PATTERN_SIZE)
  ) u_to (
    .clk     (clk),
    .we      (to_we),
    .waddr   (AW'(addr0)),
    .wdata   (byte0),
    .re      (load_out),
    .raddr   (to_rd_addr),
    .rd_data (to_rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load_out) begin
      v1 <= v0 & res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res1 <= res;
    end
  end

  assign m_axis_tvalid = v1;
  assign m_axis_tdata  = res1.use_to ? (res1.to_zero ? 8'd0 : to_rd_data)
                                     : res1.copy_byte;
endmodule
`default_nettype wire

// File: hdl/btc_checker.sv
// Port-level checker for the byte transliterator, bound to the top level.
`default_nettype none
`include "byte_transliterator_with_collapse_macros.svh"
module btc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [btc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  // a stalled result stays offered
  `BTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  // a stalled result keeps its byte
  `BTC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result byte changed while stalled")
  // nothing is offered right after reset
  `BTC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid, "result valid after reset")
  // a fresh result needs an accepted input item, registered through the input stage and result register
  `BTC_ASSERT_SAME(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without input item")
endmodule

bind byte_transliterator_with_collapse btc_checker u_checker (.*);
`default_nettype wire
